>>> hw/rtl/igps_pkg.sv
package igps_pkg;

  localparam int NUM_LIGHTS    = 16;
  localparam int NUM_LANES     = 12;
  localparam int LIGHT_W       = 4;
  localparam int LOAD_W        = 8;
  localparam int QUEUE_MAX_DEF = 255;

  localparam logic [LOAD_W-1:0] SERVE_LOAD_RST = 8'd1;

  // register index of serve_load
  localparam int REG_SERVE_LOAD = 0;

  typedef logic [NUM_LIGHTS-1:0] light_mask_t;

  // conflict list per light id, pedestrian entries mirrored into the lanes
  localparam light_mask_t CONFLICT [NUM_LIGHTS] = '{
    16'h5E98, 16'h37D8, 16'h9088, 16'hA4C7,
    16'h6EC3, 16'h3440, 16'h563A, 16'hC61F,
    16'h6202, 16'hA1D3, 16'h90FB, 16'hC011,
    16'h0467, 16'h033A, 16'h09D1, 16'h0E8C
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic               rank_en;
    logic               walk_en;
    logic               finish;
    logic [LIGHT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/igps_ctrl.sv
module igps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output igps_pkg::dp_cmd_t cmd,
  input  igps_pkg::dp_sts_t sts
);
  import igps_pkg::*;

  state_t             state_r, state_nxt;
  logic [LIGHT_W-1:0] idx_r, idx_nxt;
  logic               last;

  assign last = (idx_r == LIGHT_W'(NUM_LIGHTS - 1));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RANK;
        end
      end
      ST_RANK: begin
        if (last) begin
          state_nxt = ST_WALK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_WALK: begin
        if (last) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.idx  = idx_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_RANK: begin
        cmd.rank_en = 1'b1;
      end
      ST_WALK: begin
        cmd.walk_en = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_rank: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_RANK && idx_r == '0)
    else $error("accepted item did not start ranking at light zero");

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result written while output register is occupied");

  a_walk_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && last |=> state_r == ST_DONE)
    else $error("walk did not end after the last light");
`endif

endmodule

>>> hw/rtl/igps_dp.sv
module igps_dp #(
  parameter int QUEUE_MAX = igps_pkg::QUEUE_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  igps_pkg::dp_cmd_t             cmd,
  output igps_pkg::dp_sts_t             sts,
  input  logic [igps_pkg::NUM_LIGHTS-1:0] in_arrival_mask,
  input  logic [igps_pkg::LOAD_W-1:0]   serve_load,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [igps_pkg::NUM_LIGHTS-1:0] out_green_mask
);
  import igps_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_MAX + 1);
  localparam int SUB_W = (CNT_W > LOAD_W) ? CNT_W : LOAD_W;

  logic [CNT_W-1:0]   cnt_r   [NUM_LIGHTS];
  logic [CNT_W-1:0]   cnt_nxt [NUM_LIGHTS];
  logic [LIGHT_W-1:0] rank_r  [NUM_LIGHTS];
  logic [LIGHT_W-1:0] rank_nxt[NUM_LIGHTS];
  logic [SUB_W-1:0]   cnt_ext [NUM_LIGHTS];
  logic [SUB_W-1:0]   load_ext;
  logic [CNT_W-1:0]   cnt_cur;
  light_mask_t        green_r, green_nxt;
  light_mask_t        sel;
  light_mask_t        conf;
  logic               out_valid_r, out_valid_nxt;
  light_mask_t        out_mask_r;

  assign cnt_cur  = cnt_r[cmd.idx];
  assign load_ext = SUB_W'(serve_load);

  always_comb begin
    conf = '0;
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      sel[i] = (rank_r[i] == cmd.idx);
      if (sel[i]) begin
        conf = conf | CONFLICT[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      cnt_nxt[i]  = cnt_r[i];
      rank_nxt[i] = rank_r[i];
      cnt_ext[i]  = SUB_W'(cnt_r[i]);
      if (cmd.start) begin
        rank_nxt[i] = '0;
        if (in_arrival_mask[i] && (cnt_r[i] != CNT_W'(QUEUE_MAX))) begin
          cnt_nxt[i] = cnt_r[i] + 1'b1;
        end
      end
      if (cmd.rank_en) begin
        if ((cnt_cur > cnt_r[i]) ||
            ((cnt_cur == cnt_r[i]) && (cmd.idx < LIGHT_W'(i)))) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      if (cmd.finish && green_r[i]) begin
        if (i < NUM_LANES) begin
          if (cnt_ext[i] > load_ext) begin
            cnt_nxt[i] = CNT_W'(cnt_ext[i] - load_ext);
          end else begin
            cnt_nxt[i] = '0;
          end
        end else begin
          cnt_nxt[i] = '0;
        end
      end
    end
  end

  always_comb begin
    green_nxt = green_r;
    if (cmd.start) begin
      green_nxt = '0;
    end else if (cmd.walk_en && ((conf & green_r) == '0)) begin
      green_nxt = green_r | sel;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_green_mask = out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    green_r <= green_nxt;
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      rank_r[i] <= rank_nxt[i];
    end
    if (cmd.finish) begin
      out_mask_r <= green_r;
    end
  end

`ifndef SYNTHESIS
  a_rank_permutation: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_en |-> $onehot(sel))
    else $error("visit order does not name exactly one light");

  a_crossing_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && green_r[NUM_LIGHTS-1] |=> cnt_r[NUM_LIGHTS-1] == '0)
    else $error("green crossing count not cleared");
`endif

endmodule

>>> hw/rtl/intersection_green_phase_selector.sv
// Green phase selector for 12 vehicle lanes and 4 pedestrian crossings. Each item
// adds its arrival bits to saturating waiting counts, ranks the lights by
// descending count (lower id wins a tie), then walks them in that order and
// turns a light green when none of its fixed conflicts is already green. The
// green mask comes out as one result item; green lanes then lose serve_load
// vehicles and green crossings are cleared. An item goes through these steps in
// order: take the arrivals, rank (one light's count compared against all others
// per cycle), walk (one light tested per cycle) and write back the result into
// the output register. The next item is taken once the result is in the output
// register, so a stalled result holds off only that write-back. serve_load sits
// at byte address 0 of the register port.
module intersection_green_phase_selector #(
  parameter int QUEUE_MAX = igps_pkg::QUEUE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [igps_pkg::NUM_LIGHTS-1:0] in_arrival_mask,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [igps_pkg::NUM_LIGHTS-1:0] out_green_mask,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import igps_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [LOAD_W-1:0] serve_load_r, serve_load_nxt;
  logic              sel_serve_load;

  assign pready         = 1'b1;
  assign sel_serve_load = (paddr[2] == 1'(REG_SERVE_LOAD));
  assign prdata         = sel_serve_load ? 32'(serve_load_r) : '0;

  always_comb begin
    serve_load_nxt = serve_load_r;
    if (psel && penable && pwrite && sel_serve_load) begin
      serve_load_nxt = pwdata[LOAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      serve_load_r <= SERVE_LOAD_RST;
    end else begin
      serve_load_r <= serve_load_nxt;
    end
  end

  igps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  igps_dp #(
    .QUEUE_MAX (QUEUE_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_arrival_mask (in_arrival_mask),
    .serve_load      (serve_load_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_green_mask  (out_green_mask)
  );

endmodule

>>> bench/tb_intersection_green_phase_selector.sv
module tb_intersection_green_phase_selector;
  timeunit 1ns;
  timeprecision 1ps;

  import igps_pkg::*;

  localparam int QMAX           = QUEUE_MAX_DEF;
  localparam int REG_SPARE      = 1;
  localparam int IDLE_PCT       = 37;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT        = 450;
  localparam int CALM_FIRST     = 600;
  localparam int CALM_LAST      = 760;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  light_mask_t in_arrival_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  light_mask_t out_green_mask;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  intersection_green_phase_selector u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_arrival_mask (in_arrival_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_green_mask  (out_green_mask),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  light_mask_t pending_arrivals[$];
  light_mask_t expected_greens[$];
  light_mask_t conflict_of[NUM_LIGHTS];
  int          waiting[NUM_LIGHTS];
  int          load_model = int'(SERVE_LOAD_RST);
  int          mismatches = 0;
  int          n_sent = 0;
  int          n_results = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void build_conflict_table();
    int d;
    int a;
    int b;
    int e;
    logic [11:0] offsets;
    for (int c = 0; c < NUM_LANES; c++) begin
      // offsets relative to lane id, by lane kind
      case (c % 3)
        0: offsets = 12'hE98;
        1: offsets = 12'h3EC;
        default: offsets = 12'h022;
      endcase
      conflict_of[c] = '0;
      for (int o = 0; o < NUM_LANES; o++) begin
        if (offsets[o]) conflict_of[c][(c + o) % NUM_LANES] = 1'b1;
      end
    end
    for (int p = NUM_LANES; p < NUM_LIGHTS; p++) begin
      d = p % 4;
      a = (d * 3 + 6) % 12;
      b = (a + 4) % 12;
      e = (b + 7) % 12;
      conflict_of[p] = '0;
      conflict_of[p][d * 3]     = 1'b1;
      conflict_of[p][d * 3 + 1] = 1'b1;
      conflict_of[p][d * 3 + 2] = 1'b1;
      conflict_of[p][a] = 1'b1;
      conflict_of[p][b] = 1'b1;
      conflict_of[p][e] = 1'b1;
      for (int k = 0; k < NUM_LANES; k++) begin
        if (conflict_of[p][k]) conflict_of[k][p] = 1'b1;
      end
    end
  endfunction

  function automatic light_mask_t select_greens(light_mask_t arrivals);
    light_mask_t visited;
    light_mask_t green;
    int          best;
    bit          found;
    visited = '0;
    green = '0;
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      if (arrivals[i] && waiting[i] < QMAX) waiting[i]++;
    end
    for (int pass = 0; pass < NUM_LIGHTS; pass++) begin
      best = 0;
      found = 1'b0;
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        if (!visited[i] && (!found || waiting[i] > waiting[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      visited[best] = 1'b1;
      if ((conflict_of[best] & green) == '0) green[best] = 1'b1;
    end
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      if (green[i]) begin
        if (i < NUM_LANES) waiting[i] = (waiting[i] > load_model) ? waiting[i] - load_model : 0;
        else waiting[i] = 0;
      end
    end
    return green;
  endfunction

  function automatic light_mask_t random_arrivals(int density);
    light_mask_t m;
    for (int i = 0; i < NUM_LIGHTS; i++) begin
      m[i] = ($urandom_range(0, 99) < density);
    end
    return m;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_greens.insert(expected_greens.size(), select_greens(in_arrival_mask));
        n_sent++;
      end
      if (pending_arrivals.size() != 0 &&
          ((n_sent >= CALM_FIRST && n_sent < CALM_LAST) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_arrival_mask <= pending_arrivals.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_greens.size() == 0) begin
          report_mismatch("green_mask with no item pending", 32'(out_green_mask),
                          32'(0));
        end else begin
          light_mask_t want;
          want = expected_greens.pop_front();
          if (out_green_mask !== want)
            report_mismatch("green_mask", 32'(out_green_mask), 32'(want));
        end
        n_results++;
        if (n_results == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (n_results >= CALM_FIRST && n_results < CALM_LAST) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input int index, input logic [31:0] value);
    logic [31:0] rdata;
    apb_access(1'b1, 3'(4 * index), value, rdata);
    if (index == REG_SERVE_LOAD) load_model = int'(value[LOAD_W-1:0]);
    apb_access(1'b0, 3'(4 * REG_SERVE_LOAD), '0, rdata);
    if (rdata[LOAD_W-1:0] !== LOAD_W'(load_model))
      report_mismatch("serve_load readback", 32'(rdata[LOAD_W-1:0]), 32'(load_model));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_arrivals.size() != 0 || in_valid || expected_greens.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic queue_random(input int n, input int lo_density, input int hi_density);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        pending_arrivals.insert(pending_arrivals.size(), light_mask_t'($urandom));
      else
        pending_arrivals.insert(pending_arrivals.size(),
                                random_arrivals($urandom_range(lo_density, hi_density)));
    end
  endtask

  initial begin
    light_mask_t directed[$];
    build_conflict_table();
    for (int i = 0; i < NUM_LIGHTS; i++) waiting[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0004, 16'h0800,
                 16'h1000, 16'h2000, 16'h4000, 16'h8000, 16'h0FFF, 16'hF000,
                 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF,
                 16'hFF00, 16'h0F0F, 16'hF0F0, 16'hFFFF, 16'h0000, 16'h0000};
    foreach (directed[k]) pending_arrivals.insert(pending_arrivals.size(), directed[k]);
    wait_drained();

    // spare address must not touch serve_load
    write_reg(REG_SPARE, $urandom);
    // no load: counts climb to the ceiling
    write_reg(REG_SERVE_LOAD, 0);
    queue_random(320, 85, 100);
    wait_drained();

    // full load empties every green lane
    write_reg(REG_SERVE_LOAD, 255);
    queue_random(200, 0, 100);
    wait_drained();

    write_reg(REG_SERVE_LOAD, $urandom_range(2, 254));
    queue_random(300, 20, 100);
    wait_drained();

    write_reg(REG_SERVE_LOAD, $urandom_range(1, 8));
    queue_random(200, 30, 100);
    wait_drained();

    if (expected_greens.size() != 0)
      report_mismatch("green_mask never arrived", 32'(0), 32'(expected_greens.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
